// ===== rtl/core/gdau_pkg.sv =====
package gdau_pkg;

    localparam int unsigned EPOCH_JDN = 1721425;
    localparam int unsigned FIRST_JDN = 1721426;
    localparam int unsigned LAST_JDN  = 5373484;

    localparam logic [13:0] DEF_YEAR  = 14'd1959;
    localparam logic [3:0]  DEF_MONTH = 4'd5;
    localparam logic [4:0]  DEF_DAY   = 5'd11;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;

    typedef struct packed {
        logic        ok;
        logic        lo;
        logic        hi;
        logic [22:0] jd;
        logic [2:0]  wd;
        logic [8:0]  yday;
        logic [22:0] diff;
    } t_side;

    // Exact quotient by 100 for any 14-bit value.
    function automatic logic [7:0] div100(input logic [13:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'd5243;
        return p[26:19];
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // Days of a common year that precede the month.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/gregorian_date_arithmetic_unit.sv =====
// Channel  | Dir | Handshake              | Payload
// s (in)   | in  | i_s_tvalid, o_s_tready | i_s_tdata, 72 bits
// m (out)  | out | o_m_tvalid, i_m_tready | o_m_tdata, 88 bits
//
// One request enters per clock while the output is not stalled; results leave in request order.
// The pipeline has ten register stages: two for date to day number, one for
// the offset and range check, and seven for day number back to date.
// Reset is synchronous and clears only the stage valid bits.
// A stall at the output freezes every stage, so nothing is lost or repeated.
module gregorian_date_arithmetic_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // in_month, in_day, in_year, day_offset, other_month, other_day, other_year
    input  logic [71:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // date_valid, out_month, out_day, out_year, out_of_range, day_number,
    // weekday, year_day, days_between
    output logic [87:0] o_m_tdata
);
    import gdau_pkg::*;

    logic               adv;
    logic [9:0]         r_vld;
    logic [22:0]        r_off1;
    logic [22:0]        r_off2;

    logic               w_ok;
    logic [22:0]        w_jd;
    logic [8:0]         w_yday;
    logic               w_ook;
    logic [22:0]        w_ojd;
    logic [8:0]         w_oyday;

    logic signed [24:0] sjd;
    logic               lo;
    logic               hi;
    logic [5:0]         dsum;
    logic [3:0]         dfold;
    logic [2:0]         wd;
    t_side              n_side;
    t_side              r_side3;
    logic [21:0]        r_z3;
    t_side              r_sd [0:6];
    t_side              so;

    logic [3:0]         f_month;
    logic [4:0]         f_day;
    logic [13:0]        f_year;
    logic [3:0]         out_month;
    logic [4:0]         out_day;
    logic [13:0]        out_year;

    assign adv        = !r_vld[9] || i_m_tready;
    assign o_s_tready = adv;
    assign o_m_tvalid = r_vld[9];

    gdau_to_jdn u_base (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_month (i_s_tdata[3:0]),
        .i_day   (i_s_tdata[8:4]),
        .i_year  (i_s_tdata[22:9]),
        .o_ok    (w_ok),
        .o_jd    (w_jd),
        .o_yday  (w_yday)
    );

    gdau_to_jdn u_other (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_month (i_s_tdata[49:46]),
        .i_day   (i_s_tdata[54:50]),
        .i_year  (i_s_tdata[68:55]),
        .o_ok    (w_ook),
        .o_jd    (w_ojd),
        .o_yday  (w_oyday)
    );

    always_comb begin
        sjd   = $signed({2'b00, w_jd}) + $signed({{2{r_off2[22]}}, r_off2});
        lo    = sjd < $signed(25'(FIRST_JDN));
        hi    = sjd > $signed(25'(LAST_JDN));
        dsum  = 6'(w_jd[2:0]) + 6'(w_jd[5:3]) + 6'(w_jd[8:6]) + 6'(w_jd[11:9])
              + 6'(w_jd[14:12]) + 6'(w_jd[17:15]) + 6'(w_jd[20:18]) + 6'(w_jd[22:21]);
        dfold = 4'(dsum[5:3]) + 4'(dsum[2:0]);
        wd    = (dfold >= 4'd7) ? 3'(dfold - 4'd7) : 3'(dfold);
        n_side.ok   = w_ok;
        n_side.lo   = lo;
        n_side.hi   = hi;
        n_side.jd   = w_jd;
        n_side.wd   = wd;
        n_side.yday = w_yday;
        n_side.diff = w_ojd - w_jd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[8:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_off1  <= i_s_tdata[45:23];
            r_off2  <= r_off1;
            r_side3 <= n_side;
            r_z3    <= (lo || hi) ? 22'd0 : 22'(sjd - $signed(25'(FIRST_JDN)));
            r_sd[0] <= r_side3;
            for (int k = 1; k < 7; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    gdau_from_jdn u_date (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_z     (r_z3),
        .o_month (f_month),
        .o_day   (f_day),
        .o_year  (f_year)
    );

    always_comb begin
        so = r_sd[6];
        if (so.lo) begin
            out_month = MONTH_JAN;
            out_day   = 5'd1;
            out_year  = 14'd1;
        end else if (so.hi) begin
            out_month = MONTH_DEC;
            out_day   = 5'd31;
            out_year  = YEAR_MAX;
        end else begin
            out_month = f_month;
            out_day   = f_day;
            out_year  = f_year;
        end
        o_m_tdata = {5'd0, so.diff, so.yday, so.wd, so.jd, so.lo || so.hi,
                     out_year, out_day, out_month, so.ok};
    end

    // A substituted base date is always the default date.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !so.ok) |-> (so.jd == 23'd2436700))
        else $error("default date has wrong day number");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(so.lo && so.hi) && (so.wd <= 3'd6))
        else $error("range flags or weekday inconsistent");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !so.lo && !so.hi) |->
            (f_month >= MONTH_JAN) && (f_month <= MONTH_DEC) &&
            (f_day != 5'd0) && (f_year != 14'd0) && (f_year <= YEAR_MAX))
        else $error("shifted date outside the calendar");

endmodule

// ===== rtl/core/gdau_to_jdn.sv =====
module gdau_to_jdn (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [13:0] i_year,
    output logic        o_ok,
    output logic [22:0] o_jd,
    output logic [8:0]  o_yday
);
    import gdau_pkg::*;

    logic [7:0]  q100;
    logic [13:0] back;
    logic        leap;
    logic        ok;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [13:0] y;
    logic        lp;
    logic [8:0]  n_yday;
    logic [22:0] n_jd;

    logic        r_ok1;
    logic [13:0] r_ym1;
    logic [8:0]  r_yday1;
    logic        r_ok2;
    logic [22:0] r_jd2;
    logic [8:0]  r_yday2;

    always_comb begin
        q100 = div100(i_year);
        back = 14'({6'd0, q100} * 14'd100);
        leap = (i_year[1:0] == 2'd0) && ((back != i_year) || (q100[1:0] == 2'd0));
        ok   = (i_year != 14'd0) && (i_year <= YEAR_MAX) &&
               (i_month >= MONTH_JAN) && (i_month <= MONTH_DEC) &&
               (i_day != 5'd0) && (i_day <= month_len(i_month, leap));
        y    = ok ? i_year  : DEF_YEAR;
        m    = ok ? i_month : DEF_MONTH;
        d    = ok ? i_day   : DEF_DAY;
        lp   = ok && leap;
        n_yday = days_before(m) + 9'(d) + 9'(lp && (m > MONTH_FEB));
    end

    always_comb begin
        n_jd = 23'(EPOCH_JDN) + 23'(r_yday1) + 23'(23'(r_ym1) * 23'd365)
             + 23'(r_ym1[13:2]) - 23'(div100(r_ym1)) + 23'(div100({2'd0, r_ym1[13:2]}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok1   <= ok;
            r_ym1   <= y - 14'd1;
            r_yday1 <= n_yday;
            r_ok2   <= r_ok1;
            r_jd2   <= n_jd;
            r_yday2 <= r_yday1;
        end
    end

    assign o_ok   = r_ok2;
    assign o_jd   = r_jd2;
    assign o_yday = r_yday2;

endmodule

// ===== rtl/core/gdau_from_jdn.sv =====
module gdau_from_jdn (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [21:0] i_z,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [13:0] o_year
);
    import gdau_pkg::*;

    // P4: estimate of 400-year cycles
    logic [36:0] pa;
    logic [21:0] r_z4;
    logic [4:0]  r_qa4;
    // P5: corrected cycles and remainder
    logic [21:0] ra0;
    logic [4:0]  r_a5;
    logic [17:0] r_ra5;
    // P6: centuries
    logic [1:0]  nb;
    logic [4:0]  r_a6;
    logic [1:0]  r_b6;
    logic [15:0] r_rb6;
    // P7: estimate of 4-year cycles
    logic [37:0] pc;
    logic [4:0]  r_a7;
    logic [1:0]  r_b7;
    logic [15:0] r_rb7;
    logic [4:0]  r_qc7;
    // P8: corrected 4-year cycles
    logic [15:0] rc0;
    logic [4:0]  r_a8;
    logic [1:0]  r_b8;
    logic [4:0]  r_c8;
    logic [10:0] r_rc8;
    // P9: single years, year and ordinal day
    logic [1:0]  nd;
    logic [13:0] r_year9;
    logic [8:0]  r_doy9;
    logic        r_leap9;
    // P10: month and day
    logic [8:0]  thr [1:12];
    logic [3:0]  nm;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [13:0] r_year;

    always_comb begin
        pa  = 37'(i_z) * 37'd29398;
        ra0 = r_z4 - 22'(22'(r_qa4) * 22'd146097);
        nb  = (r_ra5 >= 18'd109572) ? 2'd3 :
              (r_ra5 >= 18'd73048)  ? 2'd2 :
              (r_ra5 >= 18'd36524)  ? 2'd1 : 2'd0;
        pc  = 38'(r_rb6) * 38'd2939744;
        rc0 = r_rb7 - 16'(16'(r_qc7) * 16'd1461);
        nd  = (r_rc8 >= 11'd1095) ? 2'd3 :
              (r_rc8 >= 11'd730)  ? 2'd2 :
              (r_rc8 >= 11'd365)  ? 2'd1 : 2'd0;
        nm  = MONTH_JAN;
        for (int k = 1; k <= 12; k++) begin
            thr[k] = days_before(4'(k)) + 9'(r_leap9 && (k > 2));
        end
        for (int k = 2; k <= 12; k++) begin
            nm = nm + 4'(r_doy9 >= thr[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z4  <= i_z;
            r_qa4 <= pa[36:32];

            if (ra0 >= 22'd146097) begin
                r_a5  <= r_qa4 + 5'd1;
                r_ra5 <= 18'(ra0 - 22'd146097);
            end else begin
                r_a5  <= r_qa4;
                r_ra5 <= 18'(ra0);
            end

            r_a6  <= r_a5;
            r_b6  <= nb;
            r_rb6 <= 16'(r_ra5 - 18'(18'(nb) * 18'd36524));

            r_a7  <= r_a6;
            r_b7  <= r_b6;
            r_rb7 <= r_rb6;
            r_qc7 <= pc[36:32];

            r_a8 <= r_a7;
            r_b8 <= r_b7;
            if (rc0 >= 16'd1461) begin
                r_c8  <= r_qc7 + 5'd1;
                r_rc8 <= 11'(rc0 - 16'd1461);
            end else begin
                r_c8  <= r_qc7;
                r_rc8 <= 11'(rc0);
            end

            r_year9 <= 14'(14'(r_a8) * 14'd400) + 14'(14'(r_b8) * 14'd100)
                     + 14'({r_c8, 2'b00}) + 14'(nd) + 14'd1;
            r_doy9  <= 9'(r_rc8 - 11'(11'(nd) * 11'd365));
            r_leap9 <= (nd == 2'd3) && ((r_c8 != 5'd24) || (r_b8 == 2'd3));

            r_month <= nm;
            r_day   <= 5'(r_doy9 - thr[nm] + 9'd1);
            r_year  <= r_year9;
        end
    end

    assign o_month = r_month;
    assign o_day   = r_day;
    assign o_year  = r_year;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] year;
        logic [22:0] offset;
        logic [3:0]  o_month;
        logic [4:0]  o_day;
        logic [13:0] o_year;
    } date_req_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] year;
        logic        oor;
        logic [22:0] jdn;
        logic [2:0]  wday;
        logic [8:0]  yday;
        logic [22:0] between;
    } date_res_t;

    typedef struct {
        date_req_t req;
        bit        typed;
        date_res_t res;
    } table_row_t;

    localparam int IDLE_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [87:0] o_m_tdata;

    date_res_t expected_dates[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        ready_hold = 0;

    gregorian_date_arithmetic_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint to_jdn(longint y, longint m, longint d);
        longint a;
        a = (m - 14) / 12;
        return d - 32075 + 1461 * (y + 4800 + a) / 4 + 367 * (m - 2 - a * 12) / 12
            - 3 * ((y + 4900 + a) / 100) / 4;
    endfunction

    function automatic void from_jdn(longint jd, output longint y, output longint m,
                                     output longint d);
        longint l, n, i, j;
        l = jd + 68569;
        n = 4 * l / 146097;
        l = l - (146097 * n + 3) / 4;
        i = 4000 * (l + 1) / 1461001;
        l = l - 1461 * i / 4 + 31;
        j = 80 * l / 2447;
        d = l - 2447 * j / 80;
        l = j / 11;
        m = j + 2 - 12 * l;
        y = 100 * (n - 49) + i + l;
    endfunction

    function automatic bit settle_date(inout longint y, inout longint m, inout longint d);
        longint ry, rm, rd;
        bit ok;
        ok = 1'b0;
        if (y >= 1 && y <= 9999) begin
            from_jdn(to_jdn(y, m, d), ry, rm, rd);
            ok = (ry == y && rm == m && rd == d);
        end
        if (!ok) begin
            y = 1959;
            m = 5;
            d = 11;
        end
        return ok;
    endfunction

    function automatic date_res_t shift_date(date_req_t q);
        date_res_t r;
        longint y, m, d, oy, om, od, jd, sjd, sy, sm, sd;
        y = q.year;
        m = q.month;
        d = q.day;
        oy = q.o_year;
        om = q.o_month;
        od = q.o_day;
        r.valid = settle_date(y, m, d);
        void'(settle_date(oy, om, od));
        jd = to_jdn(y, m, d);
        sjd = jd + longint'($signed(q.offset));
        r.oor = 1'b1;
        if (sjd < 1721426) begin
            sy = 1; sm = 1; sd = 1;
        end else if (sjd > 5373484) begin
            sy = 9999; sm = 12; sd = 31;
        end else begin
            r.oor = 1'b0;
            from_jdn(sjd, sy, sm, sd);
        end
        r.month = sm[3:0];
        r.day = sd[4:0];
        r.year = sy[13:0];
        r.jdn = jd[22:0];
        r.wday = 3'(jd % 7);
        r.yday = 9'(jd - to_jdn(y, 1, 1) + 1);
        r.between = 23'(to_jdn(oy, om, od) - jd);
        return r;
    endfunction

    function automatic logic [71:0] pack_req(date_req_t q);
        return {3'b0, q.o_year, q.o_day, q.o_month, q.offset, q.year, q.day, q.month};
    endfunction

    function automatic date_res_t unpack_res(logic [87:0] t);
        date_res_t r;
        r.valid = t[0];
        r.month = t[4:1];
        r.day = t[9:5];
        r.year = t[23:10];
        r.oor = t[24];
        r.jdn = t[47:25];
        r.wday = t[50:48];
        r.yday = t[59:51];
        r.between = t[82:60];
        return r;
    endfunction

    function automatic int month_days(int y, int m);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        if (m == 2) return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_date(date_req_t q, bit typed, date_res_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= pack_req(q);
        do @(posedge i_clk); while (!o_s_tready);
        expected_dates.push_back(typed ? want : shift_date(q));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        date_res_t got, want;
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = unpack_res(o_m_tdata);
            if (expected_dates.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_dates.pop_front();
                if (got.valid !== want.valid) report_mismatch("date_valid", got.valid, want.valid);
                if (got.month !== want.month) report_mismatch("out_month", got.month, want.month);
                if (got.day !== want.day) report_mismatch("out_day", got.day, want.day);
                if (got.year !== want.year) report_mismatch("out_year", got.year, want.year);
                if (got.oor !== want.oor) report_mismatch("out_of_range", got.oor, want.oor);
                if (got.jdn !== want.jdn) report_mismatch("day_number", got.jdn, want.jdn);
                if (got.wday !== want.wday) report_mismatch("weekday", got.wday, want.wday);
                if (got.yday !== want.yday) report_mismatch("year_day", got.yday, want.yday);
                if (got.between !== want.between) begin
                    report_mismatch("days_between", $signed(got.between), $signed(want.between));
                end
            end
        end
    end

    initial begin
        table_row_t rows[$];
        date_req_t q;
        date_res_t none;
        int y, m;
        none = '0;
        rows = '{
            '{'{4'd1, 5'd1, 14'd1, -23'sd1, 4'd1, 5'd1, 14'd1}, 1'b1,
              '{1'b1, 4'd1, 5'd1, 14'd1, 1'b1, 23'd1721426, 3'd0, 9'd1, 23'd0}},
            '{'{4'd12, 5'd31, 14'd9999, 23'sd1, 4'd12, 5'd31, 14'd9999}, 1'b1,
              '{1'b1, 4'd12, 5'd31, 14'd9999, 1'b1, 23'd5373484, 3'd4, 9'd365, 23'd0}},
            '{'{4'd1, 5'd1, 14'd1, 23'h3FFFFF, 4'd12, 5'd31, 14'd9999}, 1'b0, none},
            '{'{4'd12, 5'd31, 14'd9999, 23'h400000, 4'd1, 5'd1, 14'd1}, 1'b0, none},
            '{'{4'd1, 5'd1, 14'd1, 23'd3652058, 4'd1, 5'd1, 14'd1}, 1'b0, none},
            '{'{4'd12, 5'd31, 14'd9999, -23'sd3652058, 4'd1, 5'd1, 14'd1}, 1'b0, none},
            '{'{4'd2, 5'd29, 14'd2000, 23'd1, 4'd3, 5'd1, 14'd2000}, 1'b0, none},
            '{'{4'd2, 5'd29, 14'd1900, 23'd0, 4'd2, 5'd29, 14'd2004}, 1'b0, none},
            '{'{4'd2, 5'd30, 14'd2024, 23'd0, 4'd4, 5'd31, 14'd2024}, 1'b0, none},
            '{'{4'd0, 5'd10, 14'd2020, 23'd5, 4'd13, 5'd10, 14'd2020}, 1'b0, none},
            '{'{4'd15, 5'd31, 14'd16383, 23'd0, 4'd15, 5'd31, 14'd16383}, 1'b0, none},
            '{'{4'd5, 5'd0, 14'd0, 23'd0, 4'd5, 5'd0, 14'd0}, 1'b0, none},
            '{'{4'd6, 5'd15, 14'd10000, 23'd100, 4'd6, 5'd15, 14'd10000}, 1'b0, none},
            '{'{4'd5, 5'd11, 14'd1959, 23'd0, 4'd5, 5'd11, 14'd1959}, 1'b0, none},
            '{'{4'd12, 5'd31, 14'd2400, -23'sd366, 4'd1, 5'd1, 14'd2400}, 1'b0, none},
            '{'{4'd3, 5'd1, 14'd1600, -23'sd1, 4'd2, 5'd28, 14'd1700}, 1'b0, none},
            '{'{4'd1, 5'd31, 14'd1, -23'sd31, 4'd12, 5'd31, 14'd1}, 1'b0, none},
            '{'{4'd12, 5'd1, 14'd9999, 23'd30, 4'd11, 5'd30, 14'd9998}, 1'b0, none}
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) send_date(rows[i].req, rows[i].typed, rows[i].res);
        for (int n = 0; n < 1030; n++) begin
            if ($urandom_range(0, 9) < 8) begin
                y = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 9999);
                m = $urandom_range(1, 12);
                q.year = 14'(y);
                q.month = 4'(m);
                q.day = 5'($urandom_range(1, month_days(y, m)));
                y = $urandom_range(1, 9999);
                m = $urandom_range(1, 12);
                q.o_year = 14'(y);
                q.o_month = 4'(m);
                q.o_day = 5'($urandom_range(1, month_days(y, m)));
                case ($urandom_range(0, 3))
                    0: q.offset = 23'($signed($urandom_range(0, 2000)) - 1000);
                    1: q.offset = 23'($signed($urandom_range(0, 7304116)) - 3652058);
                    default: q.offset = 23'($urandom);
                endcase
            end else begin
                q = date_req_t'(69'({$urandom, $urandom, $urandom}));
            end
            send_date(q, 1'b0, none);
        end
        i_s_tvalid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
